FILE: hdl/qos_pkg.sv
`timescale 1ns / 1ps

package qos_pkg;

    // Fixed-point constants
    localparam logic [31:0] HALF_PI_Q29 = 32'd843314857;
    localparam logic [31:0] QTR_PI_Q29  = 32'd421657428;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [15:0] RATE_RESET  = 16'd6434;
    localparam logic signed [18:0] UNIT_Q14 = 19'sd16384;

    // Horner step indexes: sine uses 0..3, cosine 4..8
    localparam logic [4:0] HORNER_SIN_LAST = 5'd3;
    localparam logic [4:0] HORNER_LAST     = 5'd8;
    localparam logic [4:0] SQRT_LAST       = 5'd31;

    // Quaternion product: term (i,k) is p[k] * d[i^k], negated where the bit i*4+k is set
    localparam logic [15:0] TERM_NEG = 16'h428E;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_MRAW,
        OP_RAW,
        OP_REDUCE,
        OP_FOLD,
        OP_MX2,
        OP_X2,
        OP_MHT,
        OP_HDIV,
        OP_HSUB,
        OP_MSV,
        OP_SV,
        OP_TRIG,
        OP_QMUL,
        OP_QACC,
        OP_QCOPY,
        OP_NMUL,
        OP_NACC,
        OP_IDENT,
        OP_SQINIT,
        OP_SQSTEP,
        OP_NDIV,
        OP_NSTORE,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [4:0] idx;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic ge_p2;
        logic axis_on;
        logic n2_zero;
        logic div_busy;
    } t_status;

    // Series divisors, sine terms first
    function automatic logic [6:0] horner_div(input logic [4:0] idx);
        logic [6:0] k;
        case (idx)
            5'd0:    k = 7'd72;
            5'd1:    k = 7'd42;
            5'd2:    k = 7'd20;
            5'd3:    k = 7'd6;
            5'd4:    k = 7'd90;
            5'd5:    k = 7'd56;
            5'd6:    k = 7'd30;
            5'd7:    k = 7'd12;
            5'd8:    k = 7'd2;
            default: k = 7'd1;
        endcase
        return k;
    endfunction

    // floor(2^32 / divisor) for each series divisor; the estimate is low by at most one
    function automatic logic [31:0] horner_recip(input logic [4:0] idx);
        logic [31:0] m;
        case (idx)
            5'd0:    m = 32'd59652323;
            5'd1:    m = 32'd102261126;
            5'd2:    m = 32'd214748364;
            5'd3:    m = 32'd715827882;
            5'd4:    m = 32'd47721858;
            5'd5:    m = 32'd76695844;
            5'd6:    m = 32'd143165576;
            5'd7:    m = 32'd357913941;
            5'd8:    m = 32'h8000_0000;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

FILE: hdl/qos_if.sv
`timescale 1ns / 1ps

// Input request channel
interface qos_in_if;
    logic       valid;
    logic       ready;
    logic [5:0] direction_mask;
    logic [15:0] delta_time;
    modport source (output valid, output direction_mask, output delta_time, input ready);
    modport sink   (input valid, input direction_mask, input delta_time, output ready);
endinterface

// Result channel
interface qos_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    modport source (output valid, output quat_w, output quat_x, output quat_y, output quat_z,
                    input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y, input quat_z,
                    output ready);
endinterface

// Configuration write channel
interface qos_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] rotation_rate;
    modport source (output valid, output rotation_rate, input ready);
    modport sink   (input valid, input rotation_rate, output ready);
endinterface

FILE: hdl/quaternion_orientation_step_top.sv
`timescale 1ns / 1ps

// Orientation integrator: keeps a Q2.14 quaternion, and for each request
// rotates it about X, Y then Z by rotation_rate * delta_time (minus wins when
// both bits of an axis are set), renormalizes it and returns the new value.
// One request is worked at a time and occupies the block from acceptance
// until its result is loaded: four normalizing divides on the shared
// divider, 32 square-root steps, the sine/cosine series (the constant
// divides done by reciprocal multiply), the product for each selected axis
// and one range-reduction step per quarter turn (up to five). A zero-length
// result skips the square root and the divides. A finished result is held
// in the output register while the next request is already being worked on.
// Zero length gives the identity quaternion.
module quaternion_orientation_step_top (
    input logic       i_clk,
    input logic       i_rst_n,
    qos_in_if.sink    i_in,
    qos_out_if.source o_out,
    qos_cfg_if.sink   i_cfg
);
    import qos_pkg::*;

    t_cmd    cmd;
    t_status st;

    assign i_cfg.ready = 1'b1;

    qos_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_st        (st),
        .o_cmd       (cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid)
    );

    qos_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_st             (st),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_rate       (i_cfg.rotation_rate),
        .i_direction_mask (i_in.direction_mask),
        .i_delta_time     (i_in.delta_time),
        .o_quat_w         (o_out.quat_w),
        .o_quat_x         (o_out.quat_x),
        .o_quat_y         (o_out.quat_y),
        .o_quat_z         (o_out.quat_z)
    );

    // A request in flight blocks the next one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request accepted while one is in flight");

    // The divider is never restarted while running
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_NDIV) |-> !st.div_busy)
        else $error("divider started while busy");

    // A result appears only from the output load step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(cmd.op == OP_OUT))
        else $error("result valid without output load");
endmodule

FILE: hdl/qos_div.sv
`timescale 1ns / 1ps

module qos_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [44:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic [44:0] o_quot
);
    // Restoring divider, one quotient bit per cycle
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [44:0] r_quo;
    logic [31:0] r_div;
    logic [32:0] shifted;
    logic        fits;

    assign shifted = {r_rem, r_quo[44]};
    assign fits    = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 6'd45;
        end else if (r_cnt != 6'd0) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_cnt != 6'd0) begin
            r_rem <= fits ? 32'(shifted - {1'b0, r_div}) : shifted[31:0];
            r_quo <= {r_quo[43:0], fits};
        end
    end

    assign o_busy = r_cnt != 6'd0;
    assign o_quot = r_quo;
endmodule

FILE: hdl/qos_ctrl.sv
`timescale 1ns / 1ps

module qos_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  qos_pkg::t_status i_st,
    output qos_pkg::t_cmd    o_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid
);
    import qos_pkg::*;

    typedef enum logic [24:0] {
        S_IDLE   = 25'b1 << 0,
        S_MRAW   = 25'b1 << 1,
        S_RAW    = 25'b1 << 2,
        S_RED    = 25'b1 << 3,
        S_FOLD   = 25'b1 << 4,
        S_MX2    = 25'b1 << 5,
        S_X2     = 25'b1 << 6,
        S_MHT    = 25'b1 << 7,
        S_HDIV   = 25'b1 << 8,
        S_HSUB   = 25'b1 << 9,
        S_MSV    = 25'b1 << 10,
        S_SV     = 25'b1 << 11,
        S_TRIG   = 25'b1 << 12,
        S_AXIS   = 25'b1 << 13,
        S_QMUL   = 25'b1 << 14,
        S_QACC   = 25'b1 << 15,
        S_QCOPY  = 25'b1 << 16,
        S_NMUL   = 25'b1 << 17,
        S_NACC   = 25'b1 << 18,
        S_SQINIT = 25'b1 << 19,
        S_SQSTEP = 25'b1 << 20,
        S_NDIV   = 25'b1 << 21,
        S_NWAIT  = 25'b1 << 22,
        S_NSTORE = 25'b1 << 23,
        S_OUTW   = 25'b1 << 24
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_idx, n_idx;
    logic [1:0] r_axis, n_axis;
    logic       r_oval, n_oval;
    t_op        op;

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_axis  = r_axis;
        op      = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op      = OP_CAPTURE;
                    n_state = S_MRAW;
                end
            end
            S_MRAW: begin
                op      = OP_MRAW;
                n_state = S_RAW;
            end
            S_RAW: begin
                op      = OP_RAW;
                n_state = S_RED;
            end
            S_RED: begin
                if (i_st.ge_p2) begin
                    op = OP_REDUCE;
                end else begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                op      = OP_FOLD;
                n_state = S_MX2;
            end
            S_MX2: begin
                op      = OP_MX2;
                n_state = S_X2;
            end
            S_X2: begin
                op      = OP_X2;
                n_idx   = '0;
                n_state = S_MHT;
            end
            S_MHT: begin
                op      = OP_MHT;
                n_state = S_HDIV;
            end
            S_HDIV: begin
                op      = OP_HDIV;
                n_state = S_HSUB;
            end
            S_HSUB: begin
                op = OP_HSUB;
                if (r_idx == HORNER_SIN_LAST) begin
                    n_state = S_MSV;
                end else if (r_idx == HORNER_LAST) begin
                    n_state = S_TRIG;
                end else begin
                    n_idx   = r_idx + 5'd1;
                    n_state = S_MHT;
                end
            end
            S_MSV: begin
                op      = OP_MSV;
                n_state = S_SV;
            end
            S_SV: begin
                op      = OP_SV;
                n_idx   = r_idx + 5'd1;
                n_state = S_MHT;
            end
            S_TRIG: begin
                op      = OP_TRIG;
                n_axis  = '0;
                n_state = S_AXIS;
            end
            S_AXIS: begin
                n_idx = '0;
                if (r_axis == 2'd3) begin
                    n_state = S_NMUL;
                end else if (i_st.axis_on) begin
                    n_state = S_QMUL;
                end else begin
                    n_axis = r_axis + 2'd1;
                end
            end
            S_QMUL: begin
                op      = OP_QMUL;
                n_state = S_QACC;
            end
            S_QACC: begin
                op = OP_QACC;
                if (r_idx == 5'd15) begin
                    n_state = S_QCOPY;
                end else begin
                    n_idx   = r_idx + 5'd1;
                    n_state = S_QMUL;
                end
            end
            S_QCOPY: begin
                op      = OP_QCOPY;
                n_axis  = r_axis + 2'd1;
                n_state = S_AXIS;
            end
            S_NMUL: begin
                op      = OP_NMUL;
                n_state = S_NACC;
            end
            S_NACC: begin
                op = OP_NACC;
                if (r_idx == 5'd3) begin
                    n_state = S_SQINIT;
                end else begin
                    n_idx   = r_idx + 5'd1;
                    n_state = S_NMUL;
                end
            end
            S_SQINIT: begin
                n_idx = '0;
                if (i_st.n2_zero) begin
                    op      = OP_IDENT;
                    n_state = S_OUTW;
                end else begin
                    op      = OP_SQINIT;
                    n_state = S_SQSTEP;
                end
            end
            S_SQSTEP: begin
                op = OP_SQSTEP;
                if (r_idx == SQRT_LAST) begin
                    n_idx   = '0;
                    n_state = S_NDIV;
                end else begin
                    n_idx = r_idx + 5'd1;
                end
            end
            S_NDIV: begin
                op      = OP_NDIV;
                n_state = S_NWAIT;
            end
            S_NWAIT: begin
                if (!i_st.div_busy) n_state = S_NSTORE;
            end
            S_NSTORE: begin
                op = OP_NSTORE;
                if (r_idx == 5'd3) begin
                    n_state = S_OUTW;
                end else begin
                    n_idx   = r_idx + 5'd1;
                    n_state = S_NDIV;
                end
            end
            S_OUTW: begin
                if (!r_oval || i_out_ready) begin
                    op      = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Result valid flag
    always_comb begin
        n_oval = (r_oval && i_out_ready) ? 1'b0 : r_oval;
        if (op == OP_OUT) n_oval = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_axis  <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_axis  <= n_axis;
            r_oval  <= n_oval;
        end
    end

    assign o_cmd.op     = op;
    assign o_cmd.idx    = r_idx;
    assign o_cmd.axis   = r_axis;
    assign o_in_ready   = r_state == S_IDLE;
    assign o_out_valid  = r_oval;
endmodule

FILE: hdl/qos_dp.sv
`timescale 1ns / 1ps

module qos_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qos_pkg::t_cmd      i_cmd,
    output qos_pkg::t_status   o_st,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_rate,
    input  logic [5:0]         i_direction_mask,
    input  logic [15:0]        i_delta_time,
    output logic signed [15:0] o_quat_w,
    output logic signed [15:0] o_quat_x,
    output logic signed [15:0] o_quat_y,
    output logic signed [15:0] o_quat_z
);
    import qos_pkg::*;

    logic [15:0]        r_rate;
    logic [5:0]         r_mask;
    logic [15:0]        r_dt;
    logic signed [65:0] r_prod;
    logic [31:0]        r_r;
    logic [2:0]         r_q;
    logic               r_swap;
    logic [30:0]        r_x, r_x2, r_t, r_sv;
    logic [30:0]        r_hy;
    logic signed [16:0] r_c, r_s;
    logic signed [18:0] r_p [4];
    logic signed [18:0] r_nb [4];
    logic signed [37:0] r_acc;
    logic [39:0]        r_n2;
    logic [63:0]        r_v, r_res;
    logic [62:0]        r_bit;
    logic signed [15:0] r_out [4];

    logic signed [32:0] ma, mb;
    logic [1:0]         ci_sel, ck_sel, dj;
    logic [7:0]         mask_ext;
    logic               axis_minus;
    logic signed [16:0] d_val;
    logic [18:0]        mag;
    logic               div_start, div_busy;
    logic [44:0]        div_dividend, div_quot;
    logic [31:0]        div_divisor;
    logic [30:0]        h_est, h_quot;
    logic [37:0]        h_back;
    logic               h_corr;
    logic [31:0]        sv_rnd, cv_rnd;
    logic signed [16:0] si, ci, ta, tb;
    logic signed [37:0] acc_n;
    logic [63:0]        sq_sum;

    assign ci_sel     = i_cmd.idx[3:2];
    assign ck_sel     = i_cmd.idx[1:0];
    assign dj         = ci_sel ^ ck_sel;
    assign mask_ext   = {2'b00, r_mask};
    assign axis_minus = mask_ext[{i_cmd.axis, 1'b0}];

    // Rotor component for the current axis
    always_comb begin
        if (dj == 2'd0) begin
            d_val = r_c;
        end else if (dj == i_cmd.axis + 2'd1) begin
            d_val = axis_minus ? -r_s : r_s;
        end else begin
            d_val = '0;
        end
    end

    // Magnitude of the addressed component
    assign mag = r_p[i_cmd.idx[1:0]][18] ? 19'(-r_p[i_cmd.idx[1:0]])
                                          : 19'(r_p[i_cmd.idx[1:0]]);

    // Shared multiplier operand select
    always_comb begin
        case (i_cmd.op)
            OP_MRAW: begin
                ma = signed'({17'd0, r_rate});
                mb = signed'({17'd0, r_dt});
            end
            OP_MX2: begin
                ma = signed'({2'b00, r_x});
                mb = signed'({2'b00, r_x});
            end
            OP_MHT: begin
                ma = signed'({2'b00, r_x2});
                mb = signed'({2'b00, r_t});
            end
            OP_HDIV: begin
                ma = signed'({2'b00, r_prod[60:30]});
                mb = signed'({1'b0, horner_recip(i_cmd.idx)});
            end
            OP_MSV: begin
                ma = signed'({2'b00, r_x});
                mb = signed'({2'b00, r_t});
            end
            OP_QMUL: begin
                ma = 33'(r_p[ck_sel]);
                mb = 33'(d_val);
            end
            OP_NMUL: begin
                ma = signed'({14'd0, mag});
                mb = signed'({14'd0, mag});
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    // Series division by constant: reciprocal estimate plus one correction
    assign h_est  = r_prod[62:32];
    assign h_back = 38'(h_est) * 38'(horner_div(i_cmd.idx));
    assign h_corr = {7'd0, r_hy} >= h_back + 38'(horner_div(i_cmd.idx));
    assign h_quot = h_est + {30'd0, h_corr};

    // Divider feed, normalization only
    assign div_start    = i_cmd.op == OP_NDIV;
    assign div_dividend = {mag, 26'd0} + {14'd0, r_res[31:1]};
    assign div_divisor  = r_res[31:0];

    qos_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    // Round series results to Q14 and place by quadrant
    assign sv_rnd = {1'b0, r_sv} + 32'h8000;
    assign cv_rnd = {1'b0, r_t} + 32'h8000;
    assign si     = signed'({1'b0, sv_rnd[31:16]});
    assign ci     = signed'({1'b0, cv_rnd[31:16]});
    assign ta     = r_swap ? ci : si;
    assign tb     = r_swap ? si : ci;

    assign acc_n  = TERM_NEG[i_cmd.idx[3:0]] ? r_acc - 38'(r_prod) : r_acc + 38'(r_prod);
    assign sq_sum = r_res + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
        end else if (i_cfg_we) begin
            r_rate <= i_cfg_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= ma * mb;
    end

    // Orientation state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p[0] <= UNIT_Q14;
            r_p[1] <= '0;
            r_p[2] <= '0;
            r_p[3] <= '0;
        end else begin
            case (i_cmd.op)
                OP_QCOPY: begin
                    for (int j = 0; j < 4; j++) r_p[j] <= r_nb[j];
                end
                OP_IDENT: begin
                    r_p[0] <= UNIT_Q14;
                    r_p[1] <= '0;
                    r_p[2] <= '0;
                    r_p[3] <= '0;
                end
                OP_NSTORE: begin
                    if (r_p[i_cmd.idx[1:0]][18]) begin
                        r_p[i_cmd.idx[1:0]] <= (div_quot > 45'd32768) ? -19'sd32768
                                                : -signed'(19'(div_quot));
                    end else begin
                        r_p[i_cmd.idx[1:0]] <= (div_quot > 45'd32767) ? 19'sd32767
                                                : signed'(19'(div_quot));
                    end
                end
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_mask <= i_direction_mask;
                r_dt   <= i_delta_time;
            end
            OP_RAW: begin
                r_r    <= r_prod[31:0];
                r_q    <= '0;
                r_swap <= 1'b0;
            end
            OP_REDUCE: begin
                r_r <= r_r - HALF_PI_Q29;
                r_q <= r_q + 3'd1;
            end
            OP_FOLD: begin
                if (r_r > QTR_PI_Q29) begin
                    r_x    <= 31'({HALF_PI_Q29 - r_r, 1'b0});
                    r_swap <= 1'b1;
                end else begin
                    r_x <= 31'({r_r, 1'b0});
                end
            end
            OP_X2: begin
                r_x2 <= r_prod[60:30];
                r_t  <= ONE_Q30;
            end
            OP_HDIV: r_hy <= r_prod[60:30];
            OP_HSUB: r_t <= ONE_Q30 - h_quot;
            OP_SV: begin
                r_sv <= r_prod[60:30];
                r_t  <= ONE_Q30;
            end
            OP_TRIG: begin
                case (r_q[1:0])
                    2'd0: begin r_s <= ta;  r_c <= tb;  end
                    2'd1: begin r_s <= tb;  r_c <= -ta; end
                    2'd2: begin r_s <= -ta; r_c <= -tb; end
                    default: begin r_s <= -tb; r_c <= ta; end
                endcase
                r_acc <= '0;
                r_n2  <= '0;
            end
            OP_QACC: begin
                if (ck_sel == 2'd3) begin
                    r_nb[ci_sel] <= 19'((acc_n + 38'sd8192) >>> 14);
                    r_acc        <= '0;
                end else begin
                    r_acc <= acc_n;
                end
            end
            OP_NACC: r_n2 <= r_n2 + r_prod[39:0];
            OP_SQINIT: begin
                r_v   <= {r_n2, 24'd0};
                r_res <= '0;
                r_bit <= {1'b1, 62'd0};
            end
            OP_SQSTEP: begin
                if (r_v >= sq_sum) begin
                    r_v   <= r_v - sq_sum;
                    r_res <= (r_res >> 1) + {1'b0, r_bit};
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_OUT: begin
                for (int j = 0; j < 4; j++) r_out[j] <= r_p[j][15:0];
            end
            default: ;
        endcase
    end

    assign o_st.ge_p2    = r_r >= HALF_PI_Q29;
    assign o_st.axis_on  = (i_cmd.axis != 2'd3) && (mask_ext[{i_cmd.axis, 1'b0}] ||
                                                    mask_ext[{i_cmd.axis, 1'b1}]);
    assign o_st.n2_zero  = r_n2 == '0;
    assign o_st.div_busy = div_busy;

    assign o_quat_w = r_out[0];
    assign o_quat_x = r_out[1];
    assign o_quat_y = r_out[2];
    assign o_quat_z = r_out[3];
endmodule
